### rtl/integer_divide_unit_assert.svh
// ----------------------------------------------------------------------------
// Integer divide unit assertion macros
// Shared forms for the concurrent checks on the divider ports.
// ----------------------------------------------------------------------------
`ifndef INTEGER_DIVIDE_UNIT_ASSERT_SVH
`define INTEGER_DIVIDE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define IDU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("integer_divide_unit check failed");

// Next-cycle implication.
`define IDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("integer_divide_unit check failed");

// Implication after a fixed number of cycles.
`define IDU_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("integer_divide_unit check failed");

`endif

### rtl/idu_pkg.sv
// ----------------------------------------------------------------------------
// Integer divide unit package
// Request type passed from the front end through the queue to the divider.
// ----------------------------------------------------------------------------
package idu_pkg;

	localparam int QueueDepth = 2;
	localparam int DataWidth  = 64;
	localparam int HalfWidth  = 32;
	localparam logic [5:0] LastStep64 = 6'd63;
	localparam logic [5:0] LastStep32 = 6'd31;

	typedef struct packed {
		logic                 want_rem;
		logic                 neg_quo;
		logic                 neg_rem;
		logic                 wide;
		logic                 zero_div;
		logic [DataWidth-1:0] num;
		logic [DataWidth-1:0] den;
	} job_t;

endpackage

### rtl/idu_front.sv
// ----------------------------------------------------------------------------
// Integer divide unit front end
// Accepts a request, masks operands to width, takes magnitudes and notes signs.
// ----------------------------------------------------------------------------
module idu_front import idu_pkg::*; (
	input  logic                 start,
	input  logic                 full,
	input  logic [2:0]           cmd,
	input  logic [DataWidth-1:0] dividend,
	input  logic [DataWidth-1:0] divisor,
	output logic                 push,
	output job_t                 job
);

	logic                 wide;
	logic                 sgn;
	logic [DataWidth-1:0] mask;
	logic [DataWidth-1:0] a_m;
	logic [DataWidth-1:0] b_m;
	logic                 neg_a;
	logic                 neg_b;

	assign wide  = cmd[2];
	assign sgn   = cmd[1];
	assign mask  = wide ? {DataWidth{1'b1}} : {{HalfWidth{1'b0}}, {HalfWidth{1'b1}}};
	assign a_m   = dividend & mask;
	assign b_m   = divisor & mask;
	assign neg_a = sgn && (wide ? a_m[DataWidth-1] : a_m[HalfWidth-1]);
	assign neg_b = sgn && (wide ? b_m[DataWidth-1] : b_m[HalfWidth-1]);
	assign push  = start && !full;

	always_comb begin
		job.want_rem = cmd[0];
		job.neg_quo  = neg_a != neg_b;
		job.neg_rem  = neg_a;
		job.wide     = wide;
		job.zero_div = (b_m == '0);
		job.num      = neg_a ? ((~a_m + 1'b1) & mask) : a_m;
		job.den      = neg_b ? ((~b_m + 1'b1) & mask) : b_m;
	end

endmodule

### rtl/idu_queue.sv
// ----------------------------------------------------------------------------
// Integer divide unit request queue
// Short FIFO between the front end and the divider.
// ----------------------------------------------------------------------------
module idu_queue import idu_pkg::*; #(
	parameter int DEPTH = QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic full,
	output logic empty
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	job_t            entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_pop;

	assign full   = (count_q == CntW'(DEPTH));
	assign empty  = (count_q == '0);
	assign head   = entry_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/idu_back.sv
// ----------------------------------------------------------------------------
// Integer divide unit back end
// Restoring divider, one quotient bit per cycle, then sign fix-up and strobe.
// ----------------------------------------------------------------------------
module idu_back import idu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  job_t                 head,
	output logic                 pop,
	output logic                 done,
	output logic [DataWidth-1:0] answer
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIX
	} state_t;

	state_t               state_q;
	job_t                 job_q;
	logic [DataWidth-1:0] rem_q;
	logic [DataWidth-1:0] dvd_q;
	logic [DataWidth-1:0] quo_q;
	logic [5:0]           cnt_q;
	logic                 done_q;
	logic [DataWidth-1:0] answer_q;

	logic [DataWidth:0]   shifted;
	logic [DataWidth+1:0] diff;
	logic                 ge;
	logic [DataWidth-1:0] sel;
	logic                 neg;
	logic [DataWidth-1:0] signed_res;
	logic [DataWidth-1:0] mask;

	assign pop     = (state_q == ST_IDLE) && !empty;
	assign shifted = {rem_q, dvd_q[DataWidth-1]};
	assign diff    = {1'b0, shifted} - {2'b00, job_q.den};
	assign ge      = !diff[DataWidth+1];

	assign sel        = job_q.want_rem ? rem_q : quo_q;
	assign neg        = job_q.want_rem ? job_q.neg_rem : job_q.neg_quo;
	assign signed_res = neg ? (~sel + 1'b1) : sel;
	assign mask       = job_q.wide ? {DataWidth{1'b1}} : {{HalfWidth{1'b0}}, {HalfWidth{1'b1}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						job_q   <= head;
						rem_q   <= '0;
						quo_q   <= '0;
						dvd_q   <= head.wide ? head.num : {head.num[HalfWidth-1:0], {HalfWidth{1'b0}}};
						cnt_q   <= head.wide ? LastStep64 : LastStep32;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					rem_q <= ge ? diff[DataWidth-1:0] : shifted[DataWidth-1:0];
					quo_q <= {quo_q[DataWidth-2:0], ge};
					dvd_q <= {dvd_q[DataWidth-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					answer_q <= job_q.zero_div ? '0 : (signed_res & mask);
					done_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign answer = answer_q;

endmodule

### rtl/integer_divide_unit.sv
// ----------------------------------------------------------------------------
// Integer divide unit
// Quotient or remainder of 32/64-bit signed or unsigned integer division.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The divider loads a
// request from the queue, works out one quotient bit per cycle (64 or 32)
// with the serial restoring loop, then fixes the sign; the result appears on
// answer with done high for one cycle after that. A queue of QUEUE_DEPTH
// requests sits in front of the divider, which takes no new request before
// the last is done, and busy is high only while that queue is full. The
// receiver cannot stall: it must take answer in the cycle that done is high.
// A zero divisor yields 0; 32-bit answers are zero-extended.
module integer_divide_unit import idu_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           cmd,
	input  logic [DataWidth-1:0] dividend,
	input  logic [DataWidth-1:0] divisor,
	output logic                 done,
	output logic [DataWidth-1:0] answer
);

	logic push;
	job_t push_job;
	logic pop;
	job_t head;
	logic full;
	logic empty;

	assign busy = full;

	idu_front u_front (
		.start    (start),
		.full     (full),
		.cmd      (cmd),
		.dividend (dividend),
		.divisor  (divisor),
		.push     (push),
		.job      (push_job)
	);

	idu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	idu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.answer (answer)
	);

endmodule

### rtl/idu_checker.sv
// ----------------------------------------------------------------------------
// Integer divide unit checker
// Port-level checks on result spacing and queue back-pressure.
// ----------------------------------------------------------------------------
`include "integer_divide_unit_assert.svh"

module idu_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	`IDU_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`IDU_ASSERT_DELAY(a_done_gap, clk, arst_n, done, 2, !done)
	`IDU_ASSERT_IMPLY(a_busy_after_accept, clk, arst_n, $rose(busy), $past(start && !busy))

endmodule

bind integer_divide_unit idu_checker u_checker (.*);
